// ===== rtl/sorted_timer_queue_unit_defines.svh =====
// Assertion macros for the sorted timer queue.
`ifndef SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define STQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sorted timer queue check failed");

`define STQ_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sorted timer queue forbidden condition seen");

`else

`define STQ_ASSERT(name, prop)

`define STQ_ASSERT_NEVER(name, cond)

`endif

`endif

// ===== rtl/stq_pkg.sv =====
package stq_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned MaxResults     = 16;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdW     = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 3;

  localparam logic [ModeW-1:0] ModeAdd    = 2'd0;
  localparam logic [ModeW-1:0] ModeDelete = 2'd1;
  localparam logic [ModeW-1:0] ModeTick   = 2'd2;

  localparam logic [StatusW-1:0] StatusOk       = 3'd0;
  localparam logic [StatusW-1:0] StatusFull     = 3'd1;
  localparam logic [StatusW-1:0] StatusNotFound = 3'd2;
  localparam logic [StatusW-1:0] StatusExpired  = 3'd3;
  localparam logic [StatusW-1:0] StatusNone     = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] expiry_time;
    logic [TimeW-1:0] now_time;
  } stq_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     expired_id;
    logic               last;
  } stq_result_t;

endpackage

// ===== rtl/sorted_timer_queue_unit.sv =====
// Channel   Signals                        Handshake
// command   cmd_i (stq_cmd_t)              taken when start is high and busy is low
// result    result_o (stq_result_t)        valid for one cycle while result_valid_o is high
//
// The queue is a circular buffer in a memory with one read and one write port; every step
// of a scan or a shift moves one entry per cycle through that port and one 32-bit
// wrap-aware compare. Busy stays high while a delete finds and removes its timer, while an
// add removes any timer with its id and then finds its place and inserts, and while a tick pops.
// Reset empties the queue at once; the memory contents need no clearing.
// Results cannot be stalled: each appears for exactly one cycle.
`include "sorted_timer_queue_unit_defines.svh"

module sorted_timer_queue_unit #(
  parameter int unsigned Entries = stq_pkg::DefaultEntries
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  stq_pkg::stq_cmd_t     cmd_i,
  output stq_pkg::stq_result_t  result_o,
  output logic                  result_valid_o
);
  import stq_pkg::*;

  localparam int unsigned IW = $clog2(Entries);
  localparam int unsigned CW = $clog2(Entries + 1);
  localparam int unsigned SW = IW + 1;
  localparam int unsigned NW = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [TimeW-1:0] expiry;
    logic [IdW-1:0]   id;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StFind,
    StShiftDn,
    StPos,
    StShiftUp,
    StInsert,
    StTick
  } state_e;

  // Logical position l maps to slot head + l, wrapped around the buffer.
  function automatic logic [IW-1:0] phys(logic [CW-1:0] l, logic [IW-1:0] h);
    logic [SW-1:0] sum;
    sum = SW'(l) + SW'(h);
    if (sum >= SW'(Entries)) begin
      sum = sum - SW'(Entries);
    end
    return sum[IW-1:0];
  endfunction

  state_e       state_q, state_d;
  stq_cmd_t     cmd_q, cmd_d;
  logic [CW-1:0] l_q, l_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] head_q, head_d;
  logic [NW-1:0] n_q, n_d;
  logic          pend_q, pend_d;
  logic [IdW-1:0] pend_id_q, pend_id_d;
  stq_result_t   result_q, result_d;
  logic          result_valid_q, result_valid_d;

  entry_t        mem_q [Entries];
  entry_t        rd_q;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;

  logic [TimeW-1:0] cmp_lhs;
  logic [TimeW-1:0] cmp_diff;
  logic             is_earlier;
  logic             due;

  // The one compare unit: the left side is the new expiry during an add, the time on a tick.
  assign cmp_lhs    = (state_q == StTick) ? cmd_q.now_time : cmd_q.expiry_time;
  assign cmp_diff   = cmp_lhs - rd_q.expiry;
  assign is_earlier = cmp_diff[TimeW-1];
  assign due        = (count_q != '0) && (n_q != NW'(MaxResults)) && !is_earlier;

  // The read address follows the next position, so rd_q holds the entry at l_q.
  assign raddr = phys(l_d, head_d);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    l_d            = l_q;
    pos_d          = pos_q;
    count_d        = count_q;
    head_d         = head_q;
    n_d            = n_q;
    pend_d         = pend_q;
    pend_id_d      = pend_id_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    we             = 1'b0;
    waddr          = phys(l_q, head_q);
    wdata          = rd_q;

    unique case (state_q)
      StIdle: begin
        l_d = '0;
        if (start) begin
          cmd_d = cmd_i;
          unique case (cmd_i.mode) inside
            ModeAdd, ModeDelete: state_d = StFind;
            ModeTick: begin
              state_d = StTick;
              n_d     = '0;
              pend_d  = 1'b0;
            end
            default: state_d = StIdle;
          endcase
        end
      end

      StFind: begin
        if (l_q == count_q) begin
          if (cmd_q.mode == ModeDelete) begin
            result_valid_d = 1'b1;
            result_d       = '{status: StatusNotFound, expired_id: cmd_q.timer_id, last: 1'b1};
            state_d        = StIdle;
          end else if (count_q == CW'(Entries)) begin
            result_valid_d = 1'b1;
            result_d       = '{status: StatusFull, expired_id: cmd_q.timer_id, last: 1'b1};
            state_d        = StIdle;
          end else begin
            l_d     = '0;
            state_d = StPos;
          end
        end else if (rd_q.id == cmd_q.timer_id) begin
          l_d     = l_q + CW'(1);
          state_d = StShiftDn;
        end else begin
          l_d = l_q + CW'(1);
        end
      end

      StShiftDn: begin
        if (l_q == count_q) begin
          count_d = count_q - CW'(1);
          if (cmd_q.mode == ModeDelete) begin
            result_valid_d = 1'b1;
            result_d       = '{status: StatusOk, expired_id: cmd_q.timer_id, last: 1'b1};
            state_d        = StIdle;
          end else begin
            l_d     = '0;
            state_d = StPos;
          end
        end else begin
          we    = 1'b1;
          waddr = phys(l_q - CW'(1), head_q);
          l_d   = l_q + CW'(1);
        end
      end

      StPos: begin
        // The new timer goes before the first entry that it is strictly earlier than.
        if ((l_q == count_q) || is_earlier) begin
          pos_d = l_q;
          if (l_q == count_q) begin
            state_d = StInsert;
          end else begin
            l_d     = count_q - CW'(1);
            state_d = StShiftUp;
          end
        end else begin
          l_d = l_q + CW'(1);
        end
      end

      StShiftUp: begin
        we    = 1'b1;
        waddr = phys(l_q + CW'(1), head_q);
        if (l_q == pos_q) begin
          state_d = StInsert;
        end else begin
          l_d = l_q - CW'(1);
        end
      end

      StInsert: begin
        we             = 1'b1;
        waddr          = phys(pos_q, head_q);
        wdata          = '{expiry: cmd_q.expiry_time, id: cmd_q.timer_id};
        count_d        = count_q + CW'(1);
        l_d            = '0;
        result_valid_d = 1'b1;
        result_d       = '{status: StatusOk, expired_id: cmd_q.timer_id, last: 1'b1};
        state_d        = StIdle;
      end

      StTick: begin
        // Each popped id waits in pend_id_q so that the final one can carry last.
        if (due) begin
          if (pend_q) begin
            result_valid_d = 1'b1;
            result_d       = '{status: StatusExpired, expired_id: pend_id_q, last: 1'b0};
          end
          pend_d    = 1'b1;
          pend_id_d = rd_q.id;
          head_d    = (head_q == IW'(Entries - 1)) ? '0 : head_q + IW'(1);
          count_d   = count_q - CW'(1);
          n_d       = n_q + NW'(1);
        end else begin
          result_valid_d = 1'b1;
          if (pend_q) begin
            result_d = '{status: StatusExpired, expired_id: pend_id_q, last: 1'b1};
          end else begin
            result_d = '{status: StatusNone, expired_id: '0, last: 1'b1};
          end
          pend_d  = 1'b0;
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      cmd_q          <= '0;
      l_q            <= '0;
      pos_q          <= '0;
      count_q        <= '0;
      head_q         <= '0;
      n_q            <= '0;
      pend_q         <= 1'b0;
      pend_id_q      <= '0;
      result_q       <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cmd_q          <= cmd_d;
      l_q            <= l_d;
      pos_q          <= pos_d;
      count_q        <= count_d;
      head_q         <= head_d;
      n_q            <= n_d;
      pend_q         <= pend_d;
      pend_id_q      <= pend_id_d;
      result_q       <= result_d;
      result_valid_q <= result_valid_d;
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  `STQ_ASSERT_NEVER(a_count_in_range, count_q > CW'(Entries))
  `STQ_ASSERT(a_last_ends_busy, result_valid_o |-> (result_o.last == !busy))
  `STQ_ASSERT(a_empty_tick_none,
              (start && !busy && cmd_i.mode == ModeTick && count_q == '0) |->
              ##2 (result_valid_o && result_o.status == StatusNone))

endmodule

// ===== dv/sorted_timer_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module sorted_timer_queue_unit_tb;
  import stq_pkg::*;

  localparam int unsigned QueueDepth = DefaultEntries;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int unsigned RandomItems = 440;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxPrinted = 100;

  typedef struct {
    stq_cmd_t cmd;
    bit       drain_first;
  } queued_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  stq_cmd_t    cmd_i = '0;
  stq_result_t result_o;
  logic        result_valid_o;

  queued_cmd_t cmd_backlog[$];
  stq_result_t due_results[$];

  // Local copy of the timer table, kept in expiry order.
  logic [TimeW-1:0] timer_expiry[QueueDepth];
  logic [IdW-1:0]   timer_ids[QueueDepth];
  int unsigned      timer_count = 0;

  int unsigned mismatch_count = 0;
  int unsigned cmds_taken = 0;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;

  sorted_timer_queue_unit #(
    .Entries(QueueDepth)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cmd_i,
    .result_o,
    .result_valid_o
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Wrap-aware ordering: a is strictly earlier than b.
  function automatic bit expires_before(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return diff[TimeW-1];
  endfunction

  function automatic void remove_timer_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < timer_count; i++) begin
      timer_expiry[i] = timer_expiry[i+1];
      timer_ids[i]    = timer_ids[i+1];
    end
    timer_count--;
  endfunction

  function automatic bit drop_timer(logic [IdW-1:0] id);
    for (int unsigned i = 0; i < timer_count; i++) begin
      if (timer_ids[i] == id) begin
        remove_timer_at(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_due(logic [StatusW-1:0] status, logic [IdW-1:0] id, logic last);
    stq_result_t res;
    res.status     = status;
    res.expired_id = id;
    res.last       = last;
    due_results.push_back(res);
  endfunction

  function automatic void predict_timer_step(stq_cmd_t cmd);
    int unsigned pos;
    int unsigned popped;
    popped = 0;
    case (cmd.mode)
      ModeAdd: begin
        void'(drop_timer(cmd.timer_id));
        if (timer_count >= QueueDepth) begin
          push_due(StatusFull, cmd.timer_id, 1'b1);
        end else begin
          pos = 0;
          while (pos < timer_count && !expires_before(cmd.expiry_time, timer_expiry[pos])) begin
            pos++;
          end
          for (int unsigned i = timer_count; i > pos; i--) begin
            timer_expiry[i] = timer_expiry[i-1];
            timer_ids[i]    = timer_ids[i-1];
          end
          timer_expiry[pos] = cmd.expiry_time;
          timer_ids[pos]    = cmd.timer_id;
          timer_count++;
          push_due(StatusOk, cmd.timer_id, 1'b1);
        end
      end
      ModeDelete: begin
        push_due(drop_timer(cmd.timer_id) ? StatusOk : StatusNotFound, cmd.timer_id, 1'b1);
      end
      ModeTick: begin
        while (popped < MaxResults && timer_count > 0 &&
               !expires_before(cmd.now_time, timer_expiry[0])) begin
          push_due(StatusExpired, timer_ids[0], 1'b0);
          remove_timer_at(0);
          popped++;
        end
        if (popped == 0) begin
          push_due(StatusNone, '0, 1'b1);
        end else begin
          due_results[$].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_cmd(logic [ModeW-1:0] mode, logic [IdW-1:0] id,
                                    logic [TimeW-1:0] expiry, logic [TimeW-1:0] now,
                                    bit drain_first);
    queued_cmd_t item;
    item.cmd.mode        = mode;
    item.cmd.timer_id    = id;
    item.cmd.expiry_time = expiry;
    item.cmd.now_time    = now;
    item.drain_first     = drain_first;
    cmd_backlog.push_back(item);
  endfunction

  // Mostly a small pool of identifiers so that deletes and re-adds hit queued timers.
  function automatic logic [IdW-1:0] pick_timer_id();
    return ($urandom_range(0, 5) == 0) ? IdW'($urandom_range(0, 255))
                                       : IdW'($urandom_range(0, 19));
  endfunction

  function automatic bit gaps_allowed();
    return cmd_backlog.size() > 40 && ((cmds_taken / 40) % 3 != 2);
  endfunction

  // Command driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_timer_step(cmd_i);
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0 && cmd_backlog[0].drain_first &&
                     due_results.size() > 0) begin
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          if (gaps_allowed() && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 16) - 1;
            start <= 1'b0;
          end else begin
            cmd_i <= cmd_backlog[0].cmd;
            cmd_backlog.pop_front();
            start <= 1'b1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    stq_result_t want;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d id=%0d last=%0b",
                                  result_o.status, result_o.expired_id, result_o.last));
      end else begin
        want = due_results.pop_front();
        if (result_o.status !== want.status) begin
          report_mismatch($sformatf("status got %0d want %0d", result_o.status, want.status));
        end
        if (result_o.expired_id !== want.expired_id) begin
          report_mismatch($sformatf("expired_id got %0d want %0d",
                                    result_o.expired_id, want.expired_id));
        end
        if (result_o.last !== want.last) begin
          report_mismatch($sformatf("last got %0b want %0b", result_o.last, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [TimeW-1:0] clock_now;
    logic [TimeW-1:0] expiry;
    int unsigned      counted;
    int unsigned      pick;

    // Directed part: empty queue, ordering corner cases, a full queue and a mass expiry.
    queue_cmd(ModeTick, 8'd0, $urandom, 32'd0, 1'b0);
    queue_cmd(ModeDelete, 8'd0, $urandom, $urandom, 1'b0);
    for (int unsigned i = 0; i < QueueDepth; i++) begin
      if (i == 0) begin
        expiry = 32'hFFFF_FFFF;
      end else if (i == QueueDepth - 1) begin
        expiry = 32'h8000_0000;
      end else if (i <= 2) begin
        expiry = 32'd0;
      end else begin
        expiry = 10 * i;
      end
      queue_cmd(ModeAdd, IdW'(i), expiry, $urandom, 1'b0);
    end
    queue_cmd(ModeAdd, 8'd200, 32'd5, $urandom, 1'b1);
    queue_cmd(ModeAdd, 8'd5, 32'd5, $urandom, 1'b0);
    queue_cmd(ModeDelete, 8'd15, '0, '0, 1'b0);
    queue_cmd(ModeUnused, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(ModeAdd, 8'd255, 32'd3, 32'd0, 1'b0);
    queue_cmd(ModeTick, 8'hFF, 32'hFFFF_FFFF, 32'h7FFF_FFF0, 1'b0);
    queue_cmd(ModeTick, 8'd0, '0, 32'd0, 1'b0);

    // Random part; the tick clock starts just below the wrap point.
    clock_now = 32'hFFFF_F000;
    counted = 0;
    while (counted < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        expiry = ($urandom_range(0, 9) == 0) ? $urandom : clock_now + $urandom_range(0, 300);
        queue_cmd(ModeAdd, pick_timer_id(), expiry, $urandom, counted % 97 == 96);
        counted++;
      end else if (pick < 70) begin
        queue_cmd(ModeDelete, pick_timer_id(), $urandom, $urandom, counted % 97 == 96);
        counted++;
      end else if (pick < 96) begin
        if ($urandom_range(0, 9) == 0) begin
          clock_now += $urandom_range(0, 2000);
        end else begin
          clock_now += $urandom_range(0, 80);
        end
        queue_cmd(ModeTick, IdW'($urandom), $urandom,
                  ($urandom_range(0, 19) == 0) ? $urandom : clock_now, counted % 97 == 96);
        counted++;
      end else begin
        queue_cmd(ModeUnused, IdW'($urandom), $urandom, $urandom, 1'b0);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Checked on the falling edge, once the driver and the design have settled.
    while (cmd_backlog.size() > 0 || start || busy || due_results.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
